/* design/tctl_pkg.sv */
// ----------------------------------------------------------------------------
// tctl_pkg
// Shared types and constants for the threshold crossing time latch.
// ----------------------------------------------------------------------------
`default_nettype none

package tctl_pkg;

	localparam int TIME_W       = 48;
	localparam int X_W          = 32;
	localparam int DELAY_W      = 24;
	localparam int COUNT_W      = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic signed [X_W-1:0] THRESHOLD_RST = 32'sd1370000;
	localparam logic [DELAY_W-1:0]    DELAY_RST     = 24'd50000;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 1'b1;

	typedef struct packed {
		logic                  sample_valid;
		logic [TIME_W-1:0]     sample_time;
		logic signed [X_W-1:0] sample_x;
	} in_item_t;

	typedef struct packed {
		logic               crossed;
		logic               commit_now;
		logic [COUNT_W-1:0] flight_count;
		logic               times_known;
		logic [TIME_W-1:0]  cross_time;
		logic [TIME_W-1:0]  commit_time;
	} out_item_t;

	// handshake between the sequencer and an iterative unit
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

/* design/threshold_crossing_time_latch_core.sv */
// ----------------------------------------------------------------------------
// threshold_crossing_time_latch_core
// Downward threshold crossing detector with interpolated crossing time.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | in        | in_valid/in_stall  | in_item  (tctl_pkg::in_item_t)
//  out      | out       | out_valid/out_stall| out_item (tctl_pkg::out_item_t)
//  cfg      | in        | cfg_we             | cfg_index, cfg_data
//
//  an item with no crossing goes from accept through EVAL and OUT to the
//  result register; a crossing goes through EVAL, DIV, MUL and OUT, set by
//  the serial divider and then the serial multiplier, one fraction bit per cycle each
//  in_stall is high from accept until the result is loaded; a stalled
//  output holds the sequencer until its register is free
//  arst_n clears the control state (samp_q and out_q are not reset); threshold and delay return to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_crossing_time_latch_core #(
	parameter int FRACTION_BITS = tctl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire tctl_pkg::in_item_t                  in_item,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output tctl_pkg::out_item_t                      out_item,
	input  wire logic                                cfg_we,
	input  wire logic [tctl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tctl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int TW = tctl_pkg::TIME_W;
	localparam int XW = tctl_pkg::X_W;
	localparam int CW = tctl_pkg::COUNT_W;
	localparam int DW = tctl_pkg::DELAY_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic signed [XW-1:0] threshold_q;
	logic [DW-1:0]        delay_q;

	tctl_pkg::in_item_t   samp_q;
	logic                 have_last_q;
	logic [TW-1:0]        last_time_q;
	logic signed [XW-1:0] last_x_q;
	logic                 armed_q;
	logic                 active_q;
	logic [CW-1:0]        count_q;
	logic [TW-1:0]        held_cross_q;
	logic [TW-1:0]        held_commit_q;
	logic                 held_known_q;

	logic                 up_q;
	logic                 down_q;
	logic                 out_valid_q;
	tctl_pkg::out_item_t  out_q;

	tctl_pkg::unit_ctl_t  div_ctl_q;
	tctl_pkg::unit_ctl_t  mul_ctl_q;
	tctl_pkg::unit_stat_t div_stat;
	tctl_pkg::unit_stat_t mul_stat;
	logic [FRACTION_BITS:0] frac;
	logic [TW-1:0]        scaled;

	logic                 check;
	logic                 up_c;
	logic                 down_c;
	logic [XW:0]          num;
	logic [XW:0]          den;
	logic [TW-1:0]        dt;
	logic [TW-1:0]        ct;
	logic [TW:0]          cm_sum;
	logic [TW-1:0]        cm;
	logic                 out_free;
	logic                 active_n;
	logic                 known_n;
	logic [TW-1:0]        cross_n;
	logic [TW-1:0]        commit_n;
	logic [CW-1:0]        count_n;
	tctl_pkg::out_item_t  result;

	always_comb begin
		check  = have_last_q && (samp_q.sample_time > last_time_q);
		up_c   = check && !armed_q && (last_x_q <= threshold_q)
			&& (samp_q.sample_x > threshold_q);
		down_c = check && armed_q && (last_x_q > threshold_q)
			&& (samp_q.sample_x <= threshold_q);
		num    = {last_x_q[XW-1], last_x_q} - {threshold_q[XW-1], threshold_q};
		den    = {last_x_q[XW-1], last_x_q} - {samp_q.sample_x[XW-1], samp_q.sample_x};
		dt     = samp_q.sample_time - last_time_q;
		ct     = last_time_q + scaled;
		cm_sum = {1'b0, ct} + (TW+1)'(delay_q);
		cm     = cm_sum[TW] ? {TW{1'b1}} : cm_sum[TW-1:0];

		active_n = down_q ? 1'b1 : (up_q ? 1'b0 : active_q);
		known_n  = down_q | held_known_q;
		cross_n  = down_q ? ct : held_cross_q;
		commit_n = down_q ? cm : held_commit_q;
		count_n  = down_q ? count_q + CW'(1) : count_q;

		result = '0;
		if (samp_q.sample_valid) begin
			result.crossed      = down_q;
			result.commit_now   = active_n && known_n
				&& (samp_q.sample_time >= commit_n);
			result.flight_count = count_n;
			result.times_known  = known_n;
			result.cross_time   = cross_n;
			result.commit_time  = commit_n;
		end

		out_free = !out_valid_q || !out_stall;
	end

	tctl_div #(.FRAC_BITS(FRACTION_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl_q),
		.num    (num),
		.den    (den),
		.stat   (div_stat),
		.quo    (frac)
	);

	tctl_mul #(.FRAC_BITS(FRACTION_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl_q),
		.frac   (frac),
		.dt     (dt),
		.stat   (mul_stat),
		.scaled (scaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			threshold_q   <= tctl_pkg::THRESHOLD_RST;
			delay_q       <= tctl_pkg::DELAY_RST;
			have_last_q   <= 1'b0;
			last_time_q   <= '0;
			last_x_q      <= '0;
			armed_q       <= 1'b1;
			active_q      <= 1'b0;
			count_q       <= '0;
			held_cross_q  <= '0;
			held_commit_q <= '0;
			held_known_q  <= 1'b0;
			up_q          <= 1'b0;
			down_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			div_ctl_q     <= '0;
			mul_ctl_q     <= '0;
		end else begin
			div_ctl_q.start <= (state_q == ST_EVAL) && samp_q.sample_valid && down_c;
			mul_ctl_q.start <= (state_q == ST_DIV) && div_stat.done;
			out_valid_q     <= ((state_q == ST_OUT) && out_free)
				|| (out_valid_q && out_stall);
			if (cfg_we) begin
				unique case (cfg_index)
					tctl_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
					tctl_pkg::CFG_DELAY:     delay_q     <= cfg_data[DW-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					up_q   <= samp_q.sample_valid && up_c;
					down_q <= samp_q.sample_valid && down_c;
					if (samp_q.sample_valid && down_c) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (samp_q.sample_valid) begin
							have_last_q   <= 1'b1;
							last_time_q   <= samp_q.sample_time;
							last_x_q      <= samp_q.sample_x;
							armed_q       <= up_q ? 1'b1 : (down_q ? 1'b0 : armed_q);
							active_q      <= active_n;
							count_q       <= count_n;
							held_cross_q  <= cross_n;
							held_commit_q <= commit_n;
							held_known_q  <= known_n;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			samp_q <= in_item;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= result;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted item did not enter evaluation");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled result lost or changed");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its phase");

	a_cross_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.crossed) |-> out_item.times_known)
		else $error("crossing reported without latched times");

	a_commit_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.commit_now) |-> out_item.times_known)
		else $error("commit raised without latched times");

endmodule

`default_nettype wire

/* design/tctl_div.sv */
// ----------------------------------------------------------------------------
// tctl_div
// Restoring divider, one quotient bit per cycle, for a fraction in 0..1.
// ----------------------------------------------------------------------------
`default_nettype none

module tctl_div #(
	parameter int FRAC_BITS = tctl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tctl_pkg::unit_ctl_t       ctl,
	input  wire logic [tctl_pkg::X_W:0]    num,
	input  wire logic [tctl_pkg::X_W:0]    den,
	output tctl_pkg::unit_stat_t           stat,
	output logic [FRAC_BITS:0]             quo
);

	localparam int OP_W  = tctl_pkg::X_W + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic [OP_W-1:0]  rem_q;
	logic [OP_W-1:0]  den_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             first_q;
	logic             done_q;

	logic [OP_W:0]    trial;
	logic [OP_W+1:0]  diff;
	logic             ge;

	always_comb begin
		trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = ~diff[OP_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[OP_W-1:0] : trial[OP_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire

/* design/tctl_mul.sv */
// ----------------------------------------------------------------------------
// tctl_mul
// Shift-add multiplier, one fraction bit per cycle, scaled back by 2^-F.
// ----------------------------------------------------------------------------
`default_nettype none

module tctl_mul #(
	parameter int FRAC_BITS = tctl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tctl_pkg::unit_ctl_t          ctl,
	input  wire logic [FRAC_BITS:0]           frac,
	input  wire logic [tctl_pkg::TIME_W-1:0]  dt,
	output tctl_pkg::unit_stat_t              stat,
	output logic [tctl_pkg::TIME_W-1:0]       scaled
);

	localparam int TW    = tctl_pkg::TIME_W;
	localparam int ACC_W = TW + FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic [ACC_W-1:0]   acc_q;
	logic [FRAC_BITS:0] frac_q;
	logic [TW-1:0]      dt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// msb first: acc = 2*acc + bit*dt
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q  <= '0;
			frac_q <= frac;
			dt_q   <= dt;
		end else if (busy_q) begin
			acc_q  <= {acc_q[ACC_W-2:0], 1'b0}
				+ (frac_q[FRAC_BITS] ? ACC_W'(dt_q) : ACC_W'(0));
			frac_q <= {frac_q[FRAC_BITS-1:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign scaled    = acc_q[FRAC_BITS +: TW];

endmodule

`default_nettype wire
